// ===== rtl/prp_pkg.sv =====
// Shared types and codes for the pipe ring pool.
package prp_pkg;

    localparam logic [2:0] ACT_ALLOC   = 3'd0;
    localparam logic [2:0] ACT_CLOSE_R = 3'd1;
    localparam logic [2:0] ACT_CLOSE_W = 3'd2;
    localparam logic [2:0] ACT_READ    = 3'd3;
    localparam logic [2:0] ACT_WRITE   = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOFREE  = 3'd1;
    localparam logic [2:0] ST_BLOCK   = 3'd2;
    localparam logic [2:0] ST_EOF     = 3'd3;
    localparam logic [2:0] ST_EPIPE   = 3'd4;
    localparam logic [2:0] ST_IGNORED = 3'd5;

    localparam int ALLOC_LIMIT = 16;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] pipe_index;
        logic [7:0] write_data;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] read_data;
        logic [3:0] granted_index;
        logic       wake_readers;
        logic       wake_writers;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH
    } state_t;

endpackage

// ===== rtl/prp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module prp_ram
    import prp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pipe_ring_pool.sv =====
// Top level of the pipe ring pool: flags, descriptor RAM and byte RAM control.
//
//  channel | direction | valid     | stall     | payload
//  --------+-----------+-----------+-----------+---------------
//  request | in        | req_valid | req_stall | req (req_t)
//  result  | out       | rsp_valid | rsp_stall | rsp (rsp_t)
//
// A transaction passes the idle and execute states, a read returning a byte
// also the fetch state. The descriptor RAM read and the byte RAM read that
// depends on the read pointer are both registered. Reset clears the busy and
// open flags at once; the RAMs need no clearing pass. A stalled result holds
// the next transaction in execute; one new request is taken meanwhile.
module pipe_ring_pool
    import prp_pkg::*;
#(
    parameter int FIFO_COUNT = 16,
    parameter int FIFO_BYTES = 4096
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int QW    = FIFO_COUNT > 1 ? $clog2(FIFO_COUNT) : 1;
    localparam int PW    = $clog2(FIFO_BYTES);
    localparam int CW    = $clog2(FIFO_BYTES + 1);
    localparam int DW    = 2 * PW + CW;
    localparam int SPAN  = FIFO_COUNT < ALLOC_LIMIT ? FIFO_COUNT : ALLOC_LIMIT;
    localparam int BDEPTH = 1 << (QW + PW);

    state_t state_reg, state_next;
    req_t   req_reg;
    logic   rsp_valid_reg, rsp_valid_next;
    rsp_t   rsp_reg, rsp_next;
    logic [FIFO_COUNT-1:0] busy_reg, busy_next;
    logic [FIFO_COUNT-1:0] ropen_reg, ropen_next;
    logic [FIFO_COUNT-1:0] wopen_reg, wopen_next;

    logic [QW-1:0] q_in, q_cur, desc_raddr, desc_waddr;
    logic          in_range;
    logic          desc_we;
    logic [DW-1:0] desc_wdata, desc_rdata;
    logic [PW-1:0] rp, wp, rp_inc, wp_inc;
    logic [CW-1:0] cnt;
    logic          byte_we;
    logic [QW+PW-1:0] byte_waddr, byte_raddr;
    logic [7:0]    byte_rdata;
    logic          alloc_found;
    logic [3:0]    alloc_idx;
    logic          hold;

    assign q_in     = QW'(req.pipe_index);
    assign q_cur    = QW'(req_reg.pipe_index);
    assign in_range = 32'(req_reg.pipe_index) < FIFO_COUNT;
    assign rp       = desc_rdata[PW-1:0];
    assign wp       = desc_rdata[2*PW-1:PW];
    assign cnt      = desc_rdata[DW-1:2*PW];
    assign rp_inc   = (rp == PW'(FIFO_BYTES - 1)) ? '0 : rp + 1'b1;
    assign wp_inc   = (wp == PW'(FIFO_BYTES - 1)) ? '0 : wp + 1'b1;
    assign hold     = rsp_valid_reg && rsp_stall;

    assign req_stall  = (state_reg != S_IDLE);
    assign desc_raddr = (state_reg == S_IDLE) ? q_in : q_cur;

    always_comb
    begin
        alloc_found = 1'b0;
        alloc_idx   = '0;
        for (int i = SPAN - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                alloc_found = 1'b1;
                alloc_idx   = 4'(i);
            end
        end
    end

    prp_ram #(
        .WIDTH (DW),
        .DEPTH (FIFO_COUNT)
    ) u_desc_ram (
        .clk   (clk),
        .we    (desc_we),
        .waddr (desc_waddr),
        .wdata (desc_wdata),
        .raddr (desc_raddr),
        .rdata (desc_rdata)
    );

    prp_ram #(
        .WIDTH (8),
        .DEPTH (BDEPTH)
    ) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (req_reg.write_data),
        .raddr (byte_raddr),
        .rdata (byte_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        busy_next      = busy_reg;
        ropen_next     = ropen_reg;
        wopen_next     = wopen_reg;
        desc_we        = 1'b0;
        desc_waddr     = q_cur;
        desc_wdata     = desc_rdata;
        byte_we        = 1'b0;
        byte_waddr     = {q_cur, wp};
        byte_raddr     = {q_cur, rp};

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!hold)
                begin
                    rsp_next       = '0;
                    rsp_next.status = ST_IGNORED;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    unique case (req_reg.action)
                        ACT_ALLOC:
                        begin
                            if (alloc_found)
                            begin
                                busy_next[alloc_idx]  = 1'b1;
                                ropen_next[alloc_idx] = 1'b1;
                                wopen_next[alloc_idx] = 1'b1;
                                desc_we               = 1'b1;
                                desc_waddr            = QW'(alloc_idx);
                                desc_wdata            = '0;
                                rsp_next.status       = ST_OK;
                                rsp_next.granted_index = alloc_idx;
                            end
                            else
                            begin
                                rsp_next.status = ST_NOFREE;
                            end
                        end
                        ACT_CLOSE_R:
                        begin
                            if (in_range && busy_reg[q_cur] && ropen_reg[q_cur])
                            begin
                                ropen_next[q_cur]     = 1'b0;
                                busy_next[q_cur]      = wopen_reg[q_cur];
                                rsp_next.wake_writers = 1'b1;
                                rsp_next.status       = ST_OK;
                            end
                        end
                        ACT_CLOSE_W:
                        begin
                            if (in_range && busy_reg[q_cur] && wopen_reg[q_cur])
                            begin
                                wopen_next[q_cur]     = 1'b0;
                                busy_next[q_cur]      = ropen_reg[q_cur];
                                rsp_next.wake_readers = 1'b1;
                                rsp_next.status       = ST_OK;
                            end
                        end
                        ACT_READ:
                        begin
                            if (in_range)
                            begin
                                priority if (!busy_reg[q_cur])
                                begin
                                    rsp_next.status = ST_EOF;
                                end
                                else if (cnt == '0)
                                begin
                                    rsp_next.status = wopen_reg[q_cur] ? ST_BLOCK : ST_EOF;
                                end
                                else
                                begin
                                    desc_we        = 1'b1;
                                    desc_wdata     = {cnt - 1'b1, wp, rp_inc};
                                    rsp_valid_next = 1'b0;
                                    state_next     = S_FETCH;
                                end
                            end
                        end
                        ACT_WRITE:
                        begin
                            if (in_range)
                            begin
                                priority if (!busy_reg[q_cur] || !ropen_reg[q_cur])
                                begin
                                    rsp_next.status = ST_EPIPE;
                                end
                                else if (cnt == CW'(FIFO_BYTES))
                                begin
                                    rsp_next.status = ST_BLOCK;
                                end
                                else
                                begin
                                    desc_we               = 1'b1;
                                    desc_wdata            = {cnt + 1'b1, wp_inc, rp};
                                    byte_we               = 1'b1;
                                    rsp_next.wake_readers = 1'b1;
                                    rsp_next.status       = ST_OK;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                rsp_next              = '0;
                rsp_next.status       = ST_OK;
                rsp_next.read_data    = byte_rdata;
                rsp_next.wake_writers = 1'b1;
                rsp_valid_next        = 1'b1;
                state_next            = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            busy_reg      <= '0;
            ropen_reg     <= '0;
            wopen_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            busy_reg      <= busy_next;
            ropen_reg     <= ropen_next;
            wopen_reg     <= wopen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_open_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ((ropen_reg | wopen_reg) & ~busy_reg) == '0)
        else $error("open end on a free fifo");

    a_fetch_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> ($past(state_reg) == S_EXEC))
        else $error("byte fetch without execute");

    a_result_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> (state_reg == S_IDLE))
        else $error("result loaded without returning to idle");

endmodule

// ===== tb/sv/tb_pipe_ring_pool.sv =====
// Testbench for pipe_ring_pool: directed table, random pipe traffic and a self-checking predictor.
module tb_pipe_ring_pool;
    import prp_pkg::*;

    localparam int RING_BYTES = 4096;
    localparam int RING_COUNT = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_PER_PHASE = 400;
    localparam int PRESSURE_WRITES = 64;
    localparam logic [2:0] ACT_BAD_LO = 3'd5;
    localparam logic [2:0] ACT_BAD_HI = 3'd7;

    typedef struct {
        req_t req;
        bit   typed;
        rsp_t rsp;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    logic        pool_busy [RING_COUNT];
    logic        rd_open [RING_COUNT];
    logic        wr_open [RING_COUNT];
    logic [11:0] wr_ptr [RING_COUNT];
    logic [11:0] rd_ptr [RING_COUNT];
    logic [12:0] fill_cnt [RING_COUNT];
    logic [7:0]  ring_mem [RING_COUNT * RING_BYTES];

    rsp_t      pending_rsp [$];
    plan_row_t plan [$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    bit pressure_req = 1'b0;
    int error_count = 0;
    int req_count = 0;
    int rsp_count = 0;
    int full_hits = 0;
    int nofree_hits = 0;
    int quiet_cycles = 0;

    pipe_ring_pool u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    function automatic rsp_t pipe_outcome(input req_t r);
        rsp_t        o;
        logic [3:0]  q;
        logic [15:0] addr;
        bit          found;
        o = '0;
        o.status = ST_IGNORED;
        q = r.pipe_index;
        found = 1'b0;
        case (r.action)
            ACT_ALLOC:
            begin
                o.status = ST_NOFREE;
                for (int i = 0; i < ALLOC_LIMIT; i++)
                begin
                    if (!found && !pool_busy[i])
                    begin
                        found = 1'b1;
                        pool_busy[i] = 1'b1;
                        rd_open[i] = 1'b1;
                        wr_open[i] = 1'b1;
                        wr_ptr[i] = '0;
                        rd_ptr[i] = '0;
                        fill_cnt[i] = '0;
                        o.status = ST_OK;
                        o.granted_index = 4'(i);
                    end
                end
            end
            ACT_CLOSE_R:
            begin
                if (pool_busy[q] && rd_open[q])
                begin
                    rd_open[q] = 1'b0;
                    o.wake_writers = 1'b1;
                    if (!wr_open[q])
                        pool_busy[q] = 1'b0;
                    o.status = ST_OK;
                end
            end
            ACT_CLOSE_W:
            begin
                if (pool_busy[q] && wr_open[q])
                begin
                    wr_open[q] = 1'b0;
                    o.wake_readers = 1'b1;
                    if (!rd_open[q])
                        pool_busy[q] = 1'b0;
                    o.status = ST_OK;
                end
            end
            ACT_READ:
            begin
                if (!pool_busy[q])
                    o.status = ST_EOF;
                else if (fill_cnt[q] == 0)
                    o.status = wr_open[q] ? ST_BLOCK : ST_EOF;
                else
                begin
                    addr = {q, rd_ptr[q]};
                    o.read_data = ring_mem[addr];
                    rd_ptr[q] = rd_ptr[q] + 12'd1;
                    fill_cnt[q] = fill_cnt[q] - 13'd1;
                    o.wake_writers = 1'b1;
                    o.status = ST_OK;
                end
            end
            ACT_WRITE:
            begin
                if (!pool_busy[q] || !rd_open[q])
                    o.status = ST_EPIPE;
                else if (fill_cnt[q] >= RING_BYTES)
                    o.status = ST_BLOCK;
                else
                begin
                    addr = {q, wr_ptr[q]};
                    ring_mem[addr] = r.write_data;
                    wr_ptr[q] = wr_ptr[q] + 12'd1;
                    fill_cnt[q] = fill_cnt[q] + 13'd1;
                    o.wake_readers = 1'b1;
                    o.status = ST_OK;
                end
            end
            default:
                o.status = ST_IGNORED;
        endcase
        return o;
    endfunction

    function automatic req_t make_req(input logic [2:0] act, input logic [3:0] idx,
                                      input logic [7:0] data);
        req_t r;
        r.action = act;
        r.pipe_index = idx;
        r.write_data = data;
        return r;
    endfunction

    function automatic void add_row(input logic [2:0] act, input logic [3:0] idx,
                                    input logic [7:0] data, input bit typed,
                                    input logic [2:0] st, input logic [7:0] rdata,
                                    input bit wake_r, input bit wake_w);
        plan_row_t row;
        row.req = make_req(act, idx, data);
        row.typed = typed;
        row.rsp.status = st;
        row.rsp.read_data = rdata;
        row.rsp.granted_index = '0;
        row.rsp.wake_readers = wake_r;
        row.rsp.wake_writers = wake_w;
        plan.push_back(row);
    endfunction

    function automatic req_t random_pipe_req();
        req_t       r;
        logic [3:0] live [$];
        int         pick;
        r.write_data = 8'($urandom_range(255));
        r.pipe_index = 4'($urandom_range(RING_COUNT - 1));
        for (int i = 0; i < RING_COUNT; i++)
            if (pool_busy[i])
                live.push_back(4'(i));
        if (live.size() != 0)
            r.pipe_index = live[$urandom_range(live.size() - 1)];
        pick = $urandom_range(99);
        if (pick < 10)
            r.action = ACT_ALLOC;
        else if (pick < 16)
            r.action = ACT_CLOSE_R;
        else if (pick < 22)
            r.action = ACT_CLOSE_W;
        else if (pick < 58)
            r.action = ACT_WRITE;
        else if (pick < 92)
            r.action = ACT_READ;
        else
        begin
            r.action = 3'($urandom_range(7));
            r.pipe_index = 4'($urandom_range(RING_COUNT - 1));
        end
        return r;
    endfunction

    task automatic send_req(input req_t r, input bit typed, input rsp_t typed_rsp);
        rsp_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = pipe_outcome(r);
        if (r.action == ACT_WRITE && predicted.status == ST_BLOCK)
            full_hits++;
        if (predicted.status == ST_NOFREE)
            nofree_hits++;
        pending_rsp.push_back(typed ? typed_rsp : predicted);
        req_count++;
    endtask

    task automatic run_random(input int count, input int idle_pct, input int hold_pct);
        send_idle_pct = idle_pct;
        stall_pct = hold_pct;
        for (int n = 0; n < count; n++)
            send_req(random_pipe_req(), 1'b0, '0);
    endtask

    initial
    begin
        int hold_left;
        rsp_t want;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (rsp_valid && !rsp_stall)
                begin
                    rsp_count++;
                    if (pending_rsp.size() == 0)
                    begin
                        error_count++;
                        $display("%0t: unexpected transaction status %0d data %0h",
                                 $time, rsp.status, rsp.read_data);
                    end
                    else
                    begin
                        want = pending_rsp.pop_front();
                        if (rsp.status !== want.status || rsp.read_data !== want.read_data ||
                            rsp.granted_index !== want.granted_index ||
                            rsp.wake_readers !== want.wake_readers ||
                            rsp.wake_writers !== want.wake_writers)
                        begin
                            error_count++;
                            $display("%0t: mismatch exp st=%0d rd=%0h gi=%0d wr=%0b ww=%0b",
                                     $time, want.status, want.read_data,
                                     want.granted_index, want.wake_readers,
                                     want.wake_writers,
                                     " got st=%0d rd=%0h gi=%0d wr=%0b ww=%0b",
                                     rsp.status, rsp.read_data,
                                     rsp.granted_index, rsp.wake_readers,
                                     rsp.wake_writers);
                        end
                    end
                end
                if (hold_left > 0)
                begin
                    hold_left--;
                    rsp_stall <= 1'b1;
                end
                else if (pressure_req)
                begin
                    pressure_req = 1'b0;
                    hold_left = HOLD_CYCLES;
                    rsp_stall <= 1'b1;
                end
                else
                    rsp_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        rsp_t typed_rsp;
        for (int i = 0; i < RING_COUNT; i++)
        begin
            pool_busy[i] = 1'b0;
            rd_open[i] = 1'b0;
            wr_open[i] = 1'b0;
            wr_ptr[i] = '0;
            rd_ptr[i] = '0;
            fill_cnt[i] = '0;
        end

        add_row(ACT_READ,    4'd0,  8'h00, 1, ST_EOF,     8'h00, 0, 0);
        add_row(ACT_WRITE,   4'd15, 8'hFF, 1, ST_EPIPE,   8'h00, 0, 0);
        add_row(ACT_CLOSE_R, 4'd3,  8'h00, 1, ST_IGNORED, 8'h00, 0, 0);
        add_row(ACT_CLOSE_W, 4'd15, 8'h00, 1, ST_IGNORED, 8'h00, 0, 0);
        add_row(ACT_BAD_LO,  4'd9,  8'hAA, 1, ST_IGNORED, 8'h00, 0, 0);
        add_row(ACT_BAD_HI,  4'd6,  8'h55, 1, ST_IGNORED, 8'h00, 0, 0);
        add_row(ACT_ALLOC,   4'd0,  8'h00, 1, ST_OK,      8'h00, 0, 0);
        add_row(ACT_ALLOC,   4'd15, 8'hFF, 0, ST_OK,      8'h00, 0, 0);
        add_row(ACT_READ,    4'd0,  8'h00, 1, ST_BLOCK,   8'h00, 0, 0);
        add_row(ACT_WRITE,   4'd0,  8'h00, 1, ST_OK,      8'h00, 1, 0);
        add_row(ACT_WRITE,   4'd0,  8'hFF, 1, ST_OK,      8'h00, 1, 0);
        add_row(ACT_READ,    4'd0,  8'h00, 1, ST_OK,      8'h00, 0, 1);
        add_row(ACT_CLOSE_W, 4'd0,  8'h00, 1, ST_OK,      8'h00, 1, 0);
        add_row(ACT_CLOSE_W, 4'd0,  8'h00, 1, ST_IGNORED, 8'h00, 0, 0);
        add_row(ACT_READ,    4'd0,  8'h00, 1, ST_OK,      8'hFF, 0, 1);
        add_row(ACT_READ,    4'd0,  8'h00, 1, ST_EOF,     8'h00, 0, 0);
        add_row(ACT_WRITE,   4'd0,  8'h5A, 1, ST_OK,      8'h00, 1, 0);
        add_row(ACT_CLOSE_R, 4'd0,  8'h00, 1, ST_OK,      8'h00, 0, 1);
        add_row(ACT_WRITE,   4'd0,  8'hA5, 1, ST_EPIPE,   8'h00, 0, 0);
        add_row(ACT_READ,    4'd0,  8'h00, 1, ST_EOF,     8'h00, 0, 0);
        add_row(ACT_ALLOC,   4'd7,  8'h00, 1, ST_OK,      8'h00, 0, 0);
        add_row(ACT_CLOSE_R, 4'd1,  8'h00, 1, ST_OK,      8'h00, 0, 1);
        add_row(ACT_WRITE,   4'd1,  8'h81, 1, ST_EPIPE,   8'h00, 0, 0);
        add_row(ACT_READ,    4'd1,  8'h00, 1, ST_BLOCK,   8'h00, 0, 0);
        add_row(ACT_CLOSE_W, 4'd1,  8'h00, 1, ST_OK,      8'h00, 1, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_req(plan[i].req, plan[i].typed, plan[i].rsp);

        run_random(RANDOM_PER_PHASE, 0, 0);
        run_random(RANDOM_PER_PHASE, 78, 0);
        run_random(RANDOM_PER_PHASE, 0, 78);
        run_random(RANDOM_PER_PHASE, 16, 16);

        send_idle_pct = 0;
        stall_pct = 0;
        typed_rsp = '0;
        for (int i = 0; i < RING_COUNT; i++)
        begin
            send_req(make_req(ACT_CLOSE_R, 4'(i), 8'h00), 1'b0, typed_rsp);
            send_req(make_req(ACT_CLOSE_W, 4'(i), 8'h00), 1'b0, typed_rsp);
        end
        send_req(make_req(ACT_ALLOC, 4'd0, 8'h00), 1'b0, typed_rsp);
        pressure_req = 1'b1;
        for (int n = 0; n < PRESSURE_WRITES; n++)
            send_req(make_req(ACT_WRITE, 4'd0, 8'($urandom_range(255))), 1'b0, typed_rsp);
        stall_pct = 16;
        for (int n = 0; n < PRESSURE_WRITES + 2; n++)
            send_req(make_req(ACT_READ, 4'd0, 8'h00), 1'b0, typed_rsp);
        for (int n = 0; n <= ALLOC_LIMIT; n++)
            send_req(make_req(ACT_ALLOC, 4'($urandom_range(15)), 8'h00), 1'b0, typed_rsp);
        req_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests and %0d checked results under four idle profiles,",
                 req_count, rsp_count);
        $display("a long receiver hold, %0d writes to a full ring and %0d exhausted allocations.",
                 full_hits, nofree_hits);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
